>>> hw/rtl/size_class_block_allocator_top_assert.svh
// Assertion macros for the block allocator.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define SCBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication.
`define SCBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

>>> hw/rtl/scba_pkg.sv
package scba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = 6;
    localparam int LIMIT_W    = 16;
    localparam int CNT_W      = 32;
    localparam int SIZE_W     = 32;
    localparam int CFG_IDX_W  = 2;

    localparam int SMALL_POOL_DEPTH_DEF  = 32;
    localparam int MEDIUM_POOL_DEPTH_DEF = 32;
    localparam int LARGE_POOL_DEPTH_DEF  = 32;

    localparam logic [LIMIT_W-1:0] SMALL_LIMIT_RST  = 16'd64;
    localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RST = 16'd512;
    localparam logic [LIMIT_W-1:0] LARGE_LIMIT_RST  = 16'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMALL_LIMIT  = 2'd0,
        CFG_MEDIUM_LIMIT = 2'd1,
        CFG_LARGE_LIMIT  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OUT_GRANTED    = 3'd0,
        OUT_TOO_LARGE  = 3'd1,
        OUT_CLASS_FULL = 3'd2,
        OUT_FREED      = 3'd3,
        OUT_NOT_POOLED = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        CLS_SMALL  = 2'd0,
        CLS_MEDIUM = 2'd1,
        CLS_LARGE  = 2'd2
    } size_class_t;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } find_t;

    // Lowest set bit of a free map.
    function automatic find_t first_free(logic [MAX_BLOCKS-1:0] free_map);
        find_t r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--)
        begin
            if (free_map[i])
            begin
                r.found = 1'b1;
                r.idx   = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/size_class_block_allocator_top.sv
// Channel | Signals                                              | Direction
// in      | in_valid/in_ready, mode, request_size, handle_valid,  | into block
//         | block_index                                          |
// out     | out_valid/out_ready, outcome, size_class,            | out of block
//         | granted_index, alloc_total, free_total               |
// cfg     | cfg_we, cfg_index, cfg_data                          | into block
//
// One beat per cycle sustained while out_ready stays high; a result passes through the input
// register, then the result register.
// Class compare and the lowest-free search over the class map are combinational.
// Reset clears all in-use maps, both counters and the limits to their defaults.
// A stalled result holds in the result register; the input register still drains
// into it in the same cycle the result is taken.
module size_class_block_allocator_top #(
    parameter int SMALL_POOL_DEPTH  = scba_pkg::SMALL_POOL_DEPTH_DEF,
    parameter int MEDIUM_POOL_DEPTH = scba_pkg::MEDIUM_POOL_DEPTH_DEF,
    parameter int LARGE_POOL_DEPTH  = scba_pkg::LARGE_POOL_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [scba_pkg::SIZE_W-1:0]      request_size,
    input  logic                             handle_valid,
    input  logic [scba_pkg::IDX_W-1:0]       block_index,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       outcome,
    output logic [1:0]                       size_class,
    output logic [scba_pkg::IDX_W-1:0]       granted_index,
    output logic [scba_pkg::CNT_W-1:0]       alloc_total,
    output logic [scba_pkg::CNT_W-1:0]       free_total,
    input  logic                             cfg_we,
    input  logic [scba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scba_pkg::LIMIT_W-1:0]     cfg_data
);

    `include "size_class_block_allocator_top_assert.svh"

    localparam int IW = scba_pkg::IDX_W;
    localparam int MB = scba_pkg::MAX_BLOCKS;
    localparam int SW = scba_pkg::SIZE_W;
    localparam int LW = scba_pkg::LIMIT_W;
    localparam int CW = scba_pkg::CNT_W;

    logic [LW-1:0] small_limit_reg, medium_limit_reg, large_limit_reg;

    logic                in_valid_reg;
    scba_pkg::mode_t     mode_reg;
    logic [SW-1:0]       size_reg;
    logic                hvalid_reg;
    logic [IW-1:0]       idx_reg;

    logic [SMALL_POOL_DEPTH-1:0]  small_use_reg, small_use_next;
    logic [MEDIUM_POOL_DEPTH-1:0] medium_use_reg, medium_use_next;
    logic [LARGE_POOL_DEPTH-1:0]  large_use_reg, large_use_next;
    logic [CW-1:0]                alloc_cnt_reg, alloc_cnt_next;
    logic [CW-1:0]                free_cnt_reg, free_cnt_next;

    logic                  out_valid_reg;
    scba_pkg::outcome_t    outcome_reg, outcome_next;
    scba_pkg::size_class_t class_reg, class_next;
    logic [IW-1:0]         grant_reg, grant_next;

    logic                  process;
    logic                  to_heap;
    logic                  idx_ok;
    logic [MB-1:0]         free64;
    logic [MB-1:0]         set_mask, clr_mask;
    scba_pkg::find_t       ff;

    logic [SMALL_POOL_DEPTH-1:0]  small_free;
    logic [MEDIUM_POOL_DEPTH-1:0] medium_free;
    logic [LARGE_POOL_DEPTH-1:0]  large_free;

    assign process  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || process;

    assign small_free  = ~small_use_reg;
    assign medium_free = ~medium_use_reg;
    assign large_free  = ~large_use_reg;

    always_comb
    begin
        to_heap    = 1'b0;
        class_next = scba_pkg::CLS_SMALL;
        if (size_reg <= SW'(small_limit_reg))
        begin
            class_next = scba_pkg::CLS_SMALL;
        end
        else if (size_reg <= SW'(medium_limit_reg))
        begin
            class_next = scba_pkg::CLS_MEDIUM;
        end
        else if (size_reg <= SW'(large_limit_reg))
        begin
            class_next = scba_pkg::CLS_LARGE;
        end
        else
        begin
            to_heap = 1'b1;
        end
    end

    always_comb
    begin
        case (class_next)
            scba_pkg::CLS_SMALL:
            begin
                free64 = MB'(small_free);
                idx_ok = {1'b0, idx_reg} < (IW + 1)'(SMALL_POOL_DEPTH);
            end
            scba_pkg::CLS_MEDIUM:
            begin
                free64 = MB'(medium_free);
                idx_ok = {1'b0, idx_reg} < (IW + 1)'(MEDIUM_POOL_DEPTH);
            end
            scba_pkg::CLS_LARGE:
            begin
                free64 = MB'(large_free);
                idx_ok = {1'b0, idx_reg} < (IW + 1)'(LARGE_POOL_DEPTH);
            end
            default:
            begin
                free64 = '0;
                idx_ok = 1'b0;
            end
        endcase
    end

    assign ff = scba_pkg::first_free(free64);

    always_comb
    begin
        outcome_next    = scba_pkg::OUT_NOT_POOLED;
        grant_next      = '0;
        set_mask        = '0;
        clr_mask        = '0;
        alloc_cnt_next  = alloc_cnt_reg;
        free_cnt_next   = free_cnt_reg;
        if (mode_reg == scba_pkg::MODE_ALLOC)
        begin
            if (to_heap)
            begin
                outcome_next = scba_pkg::OUT_TOO_LARGE;
            end
            else if (ff.found)
            begin
                outcome_next   = scba_pkg::OUT_GRANTED;
                grant_next     = ff.idx;
                set_mask       = MB'(1) << ff.idx;
                alloc_cnt_next = alloc_cnt_reg + CW'(1);
            end
            else
            begin
                outcome_next = scba_pkg::OUT_CLASS_FULL;
            end
        end
        else if (hvalid_reg && !to_heap && idx_ok)
        begin
            outcome_next  = scba_pkg::OUT_FREED;
            clr_mask      = MB'(1) << idx_reg;
            free_cnt_next = free_cnt_reg + CW'(1);
        end
    end

    always_comb
    begin
        small_use_next  = small_use_reg;
        medium_use_next = medium_use_reg;
        large_use_next  = large_use_reg;
        case (class_next)
            scba_pkg::CLS_SMALL:
                small_use_next = (small_use_reg | SMALL_POOL_DEPTH'(set_mask))
                                 & ~SMALL_POOL_DEPTH'(clr_mask);
            scba_pkg::CLS_MEDIUM:
                medium_use_next = (medium_use_reg | MEDIUM_POOL_DEPTH'(set_mask))
                                  & ~MEDIUM_POOL_DEPTH'(clr_mask);
            scba_pkg::CLS_LARGE:
                large_use_next = (large_use_reg | LARGE_POOL_DEPTH'(set_mask))
                                 & ~LARGE_POOL_DEPTH'(clr_mask);
            default:
            begin
                small_use_next = small_use_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_limit_reg  <= scba_pkg::SMALL_LIMIT_RST;
            medium_limit_reg <= scba_pkg::MEDIUM_LIMIT_RST;
            large_limit_reg  <= scba_pkg::LARGE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                scba_pkg::CFG_SMALL_LIMIT:  small_limit_reg  <= cfg_data;
                scba_pkg::CFG_MEDIUM_LIMIT: medium_limit_reg <= cfg_data;
                scba_pkg::CFG_LARGE_LIMIT:  large_limit_reg  <= cfg_data;
                default:
                begin
                    small_limit_reg <= small_limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            small_use_reg  <= '0;
            medium_use_reg <= '0;
            large_use_reg  <= '0;
            alloc_cnt_reg  <= '0;
            free_cnt_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (process)
            begin
                out_valid_reg  <= 1'b1;
                small_use_reg  <= small_use_next;
                medium_use_reg <= medium_use_next;
                large_use_reg  <= large_use_next;
                alloc_cnt_reg  <= alloc_cnt_next;
                free_cnt_reg   <= free_cnt_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg   <= scba_pkg::mode_t'(mode);
            size_reg   <= request_size;
            hvalid_reg <= handle_valid;
            idx_reg    <= block_index;
        end
        if (process)
        begin
            outcome_reg <= outcome_next;
            class_reg   <= to_heap ? scba_pkg::CLS_SMALL : class_next;
            grant_reg   <= grant_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign outcome       = outcome_reg;
    assign size_class    = class_reg;
    assign granted_index = grant_reg;
    assign alloc_total   = alloc_cnt_reg;
    assign free_total    = free_cnt_reg;

    `SCBA_ASSERT_NOW(a_grant_idx_zero,
        out_valid_reg && outcome_reg != scba_pkg::OUT_GRANTED, grant_reg == '0)
    `SCBA_ASSERT_NEXT(a_alloc_count_step,
        process && outcome_next == scba_pkg::OUT_GRANTED,
        alloc_cnt_reg == $past(alloc_cnt_reg) + CW'(1))
    `SCBA_ASSERT_NEXT(a_counts_hold_idle,
        !process, $stable(alloc_cnt_reg) && $stable(free_cnt_reg))
    `SCBA_ASSERT_NOW(a_heap_class_small,
        out_valid_reg && outcome_reg == scba_pkg::OUT_TOO_LARGE,
        class_reg == scba_pkg::CLS_SMALL)

endmodule

>>> dv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scba_pkg::*;

    localparam int unsigned WATCHDOG_CYCLES = 5000;
    localparam int          NUM_PHASES      = 7;
    localparam int          PHASE_ITEMS     = 215;

    typedef struct {
        mode_t              mode;
        logic [SIZE_W-1:0]  size;
        logic               hv;
        logic [IDX_W-1:0]   idx;
    } request_t;

    typedef struct {
        outcome_t           outcome;
        size_class_t        cls;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   allocs;
        logic [CNT_W-1:0]   frees;
    } alloc_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   mode = 1'b0;
    logic [SIZE_W-1:0]      request_size = '0;
    logic                   handle_valid = 1'b0;
    logic [IDX_W-1:0]       block_index = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [2:0]             outcome;
    logic [1:0]             size_class;
    logic [IDX_W-1:0]       granted_index;
    logic [CNT_W-1:0]       alloc_total;
    logic [CNT_W-1:0]       free_total;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [LIMIT_W-1:0]     cfg_data = '0;

    size_class_block_allocator_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .request_size  (request_size),
        .handle_valid  (handle_valid),
        .block_index   (block_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .outcome       (outcome),
        .size_class    (size_class),
        .granted_index (granted_index),
        .alloc_total   (alloc_total),
        .free_total    (free_total),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // allocator shadow state
    logic [MAX_BLOCKS-1:0]  in_use_map [3];
    logic [LIMIT_W-1:0]     limit_reg [3];
    int                     class_blocks [3] = '{SMALL_POOL_DEPTH_DEF, MEDIUM_POOL_DEPTH_DEF,
                                                 LARGE_POOL_DEPTH_DEF};
    logic [CNT_W-1:0]       alloc_count;
    logic [CNT_W-1:0]       release_count;

    request_t               pending_q [$];
    alloc_result_t          expected_q [$];
    request_t               cur_req;
    int unsigned            idle_pct;
    int unsigned            send_gap;
    int unsigned            sink_stall;
    int unsigned            stuck_cycles;
    int unsigned            errors;
    int unsigned            requests_sent;
    int unsigned            results_seen;
    int unsigned            grants;
    int unsigned            class_fulls;
    int unsigned            releases;

    function automatic alloc_result_t predict_allocation(request_t r);
        alloc_result_t res;
        int            c;
        logic          hit;
        c = 3;
        for (int k = 2; k >= 0; k--)
        begin
            if (r.size <= {16'b0, limit_reg[k]})
                c = k;
        end
        res.outcome = OUT_NOT_POOLED;
        res.cls     = size_class_t'((c < 3) ? c : 0);
        res.idx     = '0;
        if (r.mode == MODE_ALLOC)
        begin
            if (c == 3)
                res.outcome = OUT_TOO_LARGE;
            else
            begin
                hit = 1'b0;
                for (int i = 0; i < class_blocks[c] && !hit; i++)
                begin
                    if (!in_use_map[c][i])
                    begin
                        hit              = 1'b1;
                        in_use_map[c][i] = 1'b1;
                        res.idx          = IDX_W'(i);
                    end
                end
                if (hit)
                begin
                    res.outcome = OUT_GRANTED;
                    alloc_count++;
                    grants++;
                end
                else
                begin
                    res.outcome = OUT_CLASS_FULL;
                    class_fulls++;
                end
            end
        end
        else if (r.hv && c < 3 && int'(r.idx) < class_blocks[c])
        begin
            // an already-free block still counts as a release
            in_use_map[c][r.idx] = 1'b0;
            release_count++;
            releases++;
            res.outcome = OUT_FREED;
        end
        res.allocs = alloc_count;
        res.frees  = release_count;
        return res;
    endfunction

    function automatic request_t make_request(mode_t m, logic [SIZE_W-1:0] s, logic hv,
                                              logic [IDX_W-1:0] idx);
        request_t r;
        r.mode = m;
        r.size = s;
        r.hv   = hv;
        r.idx  = idx;
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return {16'b0, limit_reg[0]};
            2:       return {16'b0, limit_reg[1]};
            3:       return {16'b0, limit_reg[2]};
            4:       return {16'b0, limit_reg[2]} + 32'd1;
            5:       return $urandom_range(0, limit_reg[0]);
            6:       return $urandom_range(0, limit_reg[2]);
            7:       return $urandom;
            8:       return '1;
            default: return $urandom_range(0, limit_reg[1] + 1);
        endcase
    endfunction

    function automatic request_t random_request(int unsigned alloc_pct);
        request_t r;
        r.mode = ($urandom_range(0, 99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
        r.size = random_size();
        r.hv   = ($urandom_range(0, 9) != 0);
        r.idx  = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(32, 63))
                                             : IDX_W'($urandom_range(0, 31));
        return r;
    endfunction

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp, act);
            errors++;
        end
    endtask

    task automatic write_limit(cfg_reg_t r, logic [LIMIT_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_reg[int'(r)] = v;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        forever #4 clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            mode         <= MODE_ALLOC;
            request_size <= '0;
            handle_valid <= 1'b0;
            block_index  <= '0;
            send_gap      = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_q.push_back(predict_allocation(cur_req));
                requests_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    cur_req       = pending_q.pop_front();
                    in_valid     <= 1'b1;
                    mode         <= cur_req.mode;
                    request_size <= cur_req.size;
                    handle_valid <= cur_req.hv;
                    block_index  <= cur_req.idx;
                    if ($urandom_range(0, 99) < idle_pct)
                        send_gap = gap_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_stall = 0;
        end
        else
        begin : sink
            alloc_result_t exp;
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat: outcome %0d class %0d", $time,
                             outcome, size_class);
                    errors++;
                end
                else
                begin
                    exp = expected_q.pop_front();
                    report_field("outcome", exp.outcome, outcome);
                    report_field("size_class", exp.cls, size_class);
                    report_field("granted_index", exp.idx, granted_index);
                    report_field("alloc_total", exp.allocs, alloc_total);
                    report_field("free_total", exp.frees, free_total);
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                sink_stall = gap_len() - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles = 0;
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_CYCLES)
            begin
                $display("%0t: watchdog expired, %0d results still outstanding", $time,
                         expected_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [LIMIT_W-1:0] phase_limits [NUM_PHASES][3];
        phase_limits = '{'{16'd64, 16'd512, 16'd4096}, '{16'd1, 16'd1, 16'd1},
                         '{16'hFFFF, 16'hFFFF, 16'hFFFF}, '{16'd100, 16'd50, 16'd2000},
                         '{16'd16, 16'd256, 16'hFFFF}, '{16'hFFFF, 16'd1, 16'd1},
                         '{16'd8, 16'd8, 16'd300}};
        for (int c = 0; c < 3; c++)
            in_use_map[c] = '0;
        limit_reg     = '{SMALL_LIMIT_RST, MEDIUM_LIMIT_RST, LARGE_LIMIT_RST};
        alloc_count   = '0;
        release_count = '0;
        idle_pct      = 20;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: class edges, heap fallback, null and out-of-range handles
        pending_q.push_back(make_request(MODE_ALLOC, 32'd0, 1'b0, 6'd0));
        pending_q.push_back(make_request(MODE_ALLOC, 32'd64, 1'b0, 6'd0));
        pending_q.push_back(make_request(MODE_ALLOC, 32'd65, 1'b0, 6'd0));
        pending_q.push_back(make_request(MODE_ALLOC, 32'd512, 1'b0, 6'd0));
        pending_q.push_back(make_request(MODE_ALLOC, 32'd513, 1'b0, 6'd0));
        pending_q.push_back(make_request(MODE_ALLOC, 32'd4096, 1'b0, 6'd0));
        pending_q.push_back(make_request(MODE_ALLOC, 32'd4097, 1'b0, 6'd0));
        pending_q.push_back(make_request(MODE_ALLOC, 32'hFFFF_FFFF, 1'b1, 6'd63));
        pending_q.push_back(make_request(MODE_FREE, 32'd0, 1'b0, 6'd0));
        pending_q.push_back(make_request(MODE_FREE, 32'd5000, 1'b1, 6'd0));
        pending_q.push_back(make_request(MODE_FREE, 32'd10, 1'b1, 6'd32));
        pending_q.push_back(make_request(MODE_FREE, 32'd10, 1'b1, 6'd63));
        pending_q.push_back(make_request(MODE_FREE, 32'd10, 1'b1, 6'd0));
        pending_q.push_back(make_request(MODE_FREE, 32'd10, 1'b1, 6'd0));
        pending_q.push_back(make_request(MODE_ALLOC, 32'd1, 1'b0, 6'd0));
        pending_q.push_back(make_request(MODE_FREE, 32'd300, 1'b1, 6'd31));
        pending_q.push_back(make_request(MODE_FREE, 32'd4096, 1'b1, 6'd1));
        pending_q.push_back(make_request(MODE_ALLOC, 32'd0, 1'b1, 6'd63));
        pending_q.push_back(make_request(MODE_FREE, 32'hFFFF_FFFF, 1'b0, 6'd63));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            write_limit(CFG_SMALL_LIMIT, phase_limits[p][0]);
            write_limit(CFG_MEDIUM_LIMIT, phase_limits[p][1]);
            write_limit(CFG_LARGE_LIMIT, phase_limits[p][2]);
            @(negedge clk);
            idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40);
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_q.push_back(random_request((p % 2 == 0) ? 75 : 40));
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Covered %0d requests over %0d limit settings: %0d grants, %0d class-full",
                 requests_sent, NUM_PHASES + 1, grants, class_fulls);
        $display("fallbacks, %0d releases, %0d result beats checked", releases, results_seen);
        if (errors == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> size_class_block_allocator_top.f
+incdir+hw/rtl
hw/rtl/scba_pkg.sv
hw/rtl/size_class_block_allocator_top.sv
dv/testbench.sv
